// ===== rtl/jndm_pkg.sv =====
// Shared types and constants for the joystick normalize / drive mix block.
`default_nettype none

package jndm_pkg;

    localparam int DEF_SAMPLE_BITS   = 12;
    localparam int DEF_FRACTION_BITS = 15;

    localparam int CFG_IDX_W = 3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X = 3'd0,
        CFG_CENTER_Y = 3'd1,
        CFG_MIN_X    = 3'd2,
        CFG_MAX_X    = 3'd3,
        CFG_MIN_Y    = 3'd4,
        CFG_MAX_Y    = 3'd5
    } t_cfg_reg;

    // per-axis classification made at accept time
    typedef struct packed {
        logic neg;   // sample below center
        logic zero;  // on center or zero span: axis forced to 0
    } t_axis_cls;

    typedef struct packed {
        logic      uncal;  // min == max on some axis
        t_axis_cls x;
        t_axis_cls y;
    } t_item_cls;

endpackage

`default_nettype wire

// ===== rtl/jndm_front.sv =====
// Front end: calibration registers, input handshake and per-axis classification.
`default_nettype none

module jndm_front #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [jndm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [SAMPLE_BITS-1:0]            i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [SAMPLE_BITS-1:0]            i_raw_x,
    input  logic [SAMPLE_BITS-1:0]            i_raw_y,
    input  logic                              i_q_ready,
    output logic                              o_push,
    output jndm_pkg::t_item_cls               o_cls,
    output logic [SAMPLE_BITS-1:0]            o_diff_x,
    output logic [SAMPLE_BITS-1:0]            o_span_x,
    output logic [SAMPLE_BITS-1:0]            o_diff_y,
    output logic [SAMPLE_BITS-1:0]            o_span_y
);
    import jndm_pkg::*;

    localparam int S = SAMPLE_BITS;

    logic [S-1:0] r_center_x, r_center_y, r_min_x, r_max_x, r_min_y, r_max_y;

    logic [S-1:0] w_raw  [0:1];
    logic [S-1:0] w_cen  [0:1];
    logic [S-1:0] w_lo   [0:1];
    logic [S-1:0] w_hi   [0:1];
    logic [S-1:0] w_diff [0:1];
    logic [S-1:0] w_span [0:1];
    t_axis_cls    w_ax   [0:1];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_min_x    <= '0;
            r_max_x    <= '0;
            r_min_y    <= '0;
            r_max_y    <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_CENTER_X: r_center_x <= i_cfg_data;
                CFG_CENTER_Y: r_center_y <= i_cfg_data;
                CFG_MIN_X:    r_min_x    <= i_cfg_data;
                CFG_MAX_X:    r_max_x    <= i_cfg_data;
                CFG_MIN_Y:    r_min_y    <= i_cfg_data;
                CFG_MAX_Y:    r_max_y    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_raw[0] = i_raw_x;
    assign w_raw[1] = i_raw_y;
    assign w_cen[0] = r_center_x;
    assign w_cen[1] = r_center_y;
    assign w_lo[0]  = r_min_x;
    assign w_lo[1]  = r_min_y;
    assign w_hi[0]  = r_max_x;
    assign w_hi[1]  = r_max_y;

    always_comb begin
        logic [S-1:0] v_lo_span;
        logic [S-1:0] v_hi_span;
        for (int a = 0; a < 2; a++) begin
            // span is an absolute distance, so a swapped min/max still divides
            v_lo_span = (w_cen[a] >= w_lo[a]) ? (w_cen[a] - w_lo[a]) : (w_lo[a] - w_cen[a]);
            v_hi_span = (w_hi[a] >= w_cen[a]) ? (w_hi[a] - w_cen[a]) : (w_cen[a] - w_hi[a]);
            priority if (w_raw[a] < w_cen[a]) begin
                w_diff[a]   = w_cen[a] - w_raw[a];
                w_span[a]   = v_lo_span;
                w_ax[a].neg = 1'b1;
            end else if (w_raw[a] > w_cen[a]) begin
                w_diff[a]   = w_raw[a] - w_cen[a];
                w_span[a]   = v_hi_span;
                w_ax[a].neg = 1'b0;
            end else begin
                w_diff[a]   = '0;
                w_span[a]   = '0;
                w_ax[a].neg = 1'b0;
            end
            w_ax[a].zero = (w_diff[a] == '0) || (w_span[a] == '0);
        end
    end

    assign o_in_ready = i_q_ready;
    assign o_push     = i_in_valid && i_q_ready;

    assign o_cls.uncal = (r_min_x == r_max_x) || (r_min_y == r_max_y);
    assign o_cls.x     = w_ax[0];
    assign o_cls.y     = w_ax[1];
    assign o_diff_x    = w_diff[0];
    assign o_span_x    = w_span[0];
    assign o_diff_y    = w_diff[1];
    assign o_span_y    = w_span[1];

endmodule

`default_nettype wire

// ===== rtl/jndm_queue.sv =====
// Small FIFO between the front end and the divide/mix pipeline.
`default_nettype none

module jndm_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    import jndm_pkg::*;

    logic [WIDTH-1:0]    r_mem [0:QUEUE_DEPTH-1];
    logic [QUEUE_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic [QUEUE_AW:0]   n_count;

    assign o_ready = (r_count != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/jndm_back.sv =====
// Back end: pipelined restoring divider, deadband, drive mixing and output register.
`default_nettype none

module jndm_back #(
    parameter int SAMPLE_BITS   = 12,
    parameter int FRACTION_BITS = 15
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_pop,
    input  jndm_pkg::t_item_cls               i_cls,
    input  logic [SAMPLE_BITS-1:0]            i_diff_x,
    input  logic [SAMPLE_BITS-1:0]            i_span_x,
    input  logic [SAMPLE_BITS-1:0]            i_diff_y,
    input  logic [SAMPLE_BITS-1:0]            i_span_y,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [FRACTION_BITS+1:0]   o_norm_x,
    output logic signed [FRACTION_BITS+1:0]   o_norm_y,
    output logic [7:0]                        o_left_speed,
    output logic                              o_left_reverse,
    output logic [7:0]                        o_right_speed,
    output logic                              o_right_reverse,
    output logic                              o_not_calibrated
);
    import jndm_pkg::*;

    localparam int S    = SAMPLE_BITS;
    localparam int F    = FRACTION_BITS;
    localparam int ND   = F;        // one quotient bit per stage
    localparam int LAST = ND + 3;   // normalize, mix, output after the divider

    localparam logic [F:0]          ONE_Q  = {1'b1, {F{1'b0}}};
    localparam logic signed [F+2:0] ONE_S  = signed'({2'b00, ONE_Q});
    localparam logic [F+5:0]        DB_LIM = {5'b00000, ONE_Q};

    logic en;

    logic [LAST:0] r_vld;

    // divider stages: index 0 holds the loaded operands
    logic [S-1:0] r_rem  [0:1][0:ND-1];
    logic [S-1:0] r_span [0:1][0:ND-1];
    logic [F-1:0] r_q    [0:1][0:ND];
    logic         r_sat  [0:1][0:ND];
    t_item_cls    r_cls  [0:ND];

    logic [S-1:0] n_rem [0:1][1:ND-1];
    logic [F-1:0] n_q   [0:1][1:ND];

    // normalize stage
    logic signed [F+1:0] r_norm_n [0:1];
    logic                r_unc_n;
    logic signed [F+1:0] n_norm   [0:1];

    // mix stage
    logic signed [F+1:0] r_norm_m [0:1];
    logic [F:0]          r_mag_m  [0:1];
    logic                r_rev_m  [0:1];
    logic                r_unc_m;
    logic [F:0]          n_mag    [0:1];
    logic                n_rev    [0:1];

    // output register
    logic signed [F+1:0] r_out_norm [0:1];
    logic [7:0]          r_out_spd  [0:1];
    logic                r_out_rev  [0:1];
    logic                r_out_unc;
    logic [7:0]          n_spd      [0:1];

    assign en    = !r_vld[LAST] || i_out_ready;
    assign o_pop = en && i_valid;

    // one restoring step per stage
    always_comb begin
        logic [S:0] v_sh;
        logic [S:0] v_sub;
        logic       v_ge;
        for (int a = 0; a < 2; a++) begin
            for (int k = 1; k < ND; k++) begin
                v_sh  = {r_rem[a][k-1], 1'b0};
                v_ge  = v_sh >= {1'b0, r_span[a][k-1]};
                v_sub = v_sh - {1'b0, r_span[a][k-1]};
                n_rem[a][k] = v_ge ? v_sub[S-1:0] : v_sh[S-1:0];
                n_q[a][k]   = {r_q[a][k-1][F-2:0], v_ge};
            end
            v_sh  = {r_rem[a][ND-1], 1'b0};
            v_ge  = v_sh >= {1'b0, r_span[a][ND-1]};
            n_q[a][ND] = {r_q[a][ND-1][F-2:0], v_ge};
        end
    end

    // saturate, 5% deadband, sign
    always_comb begin
        t_axis_cls  v_ax;
        logic [F:0] v_mag;
        logic [F+5:0] v_m20;
        for (int a = 0; a < 2; a++) begin
            v_ax = (a == 0) ? r_cls[ND].x : r_cls[ND].y;
            priority if (v_ax.zero) begin
                v_mag = '0;
            end else if (r_sat[a][ND]) begin
                v_mag = ONE_Q;
            end else begin
                v_mag = {1'b0, r_q[a][ND]};
            end
            v_m20 = (F+6)'({v_mag, 4'b0000}) + (F+6)'({v_mag, 2'b00});
            if (v_m20 < DB_LIM) begin
                v_mag = '0;
            end
            if (r_cls[ND].uncal) begin
                n_norm[a] = '0;
            end else if (v_ax.neg) begin
                n_norm[a] = -signed'({1'b0, v_mag});
            end else begin
                n_norm[a] = signed'({1'b0, v_mag});
            end
        end
    end

    // left = y + x, right = y - x, clamp to full scale, split sign
    always_comb begin
        logic signed [F+2:0] v_sum;
        for (int b = 0; b < 2; b++) begin
            if (b == 0) begin
                v_sum = (F+3)'(r_norm_n[1]) + (F+3)'(r_norm_n[0]);
            end else begin
                v_sum = (F+3)'(r_norm_n[1]) - (F+3)'(r_norm_n[0]);
            end
            if (v_sum > ONE_S) begin
                v_sum = ONE_S;
            end else if (v_sum < -ONE_S) begin
                v_sum = -ONE_S;
            end
            n_rev[b] = v_sum[F+2];
            if (v_sum[F+2]) begin
                v_sum = -v_sum;
            end
            n_mag[b] = v_sum[F:0];
        end
    end

    // speed = floor(mag * 255 / ONE)
    always_comb begin
        logic [F+8:0] v_p;
        for (int b = 0; b < 2; b++) begin
            v_p      = {r_mag_m[b], 8'h00} - (F+9)'(r_mag_m[b]);
            n_spd[b] = v_p[F+7:F];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAST-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rem[0][0]  <= i_diff_x;
            r_span[0][0] <= i_span_x;
            r_sat[0][0]  <= i_diff_x >= i_span_x;
            r_rem[1][0]  <= i_diff_y;
            r_span[1][0] <= i_span_y;
            r_sat[1][0]  <= i_diff_y >= i_span_y;
            r_q[0][0]    <= '0;
            r_q[1][0]    <= '0;
            r_cls[0]     <= i_cls;
            for (int k = 1; k <= ND; k++) begin
                r_cls[k] <= r_cls[k-1];
                for (int a = 0; a < 2; a++) begin
                    r_q[a][k]   <= n_q[a][k];
                    r_sat[a][k] <= r_sat[a][k-1];
                end
            end
            for (int k = 1; k < ND; k++) begin
                for (int a = 0; a < 2; a++) begin
                    r_rem[a][k]  <= n_rem[a][k];
                    r_span[a][k] <= r_span[a][k-1];
                end
            end
            r_unc_n <= r_cls[ND].uncal;
            r_unc_m <= r_unc_n;
            r_out_unc <= r_unc_m;
            for (int a = 0; a < 2; a++) begin
                r_norm_n[a]   <= n_norm[a];
                r_norm_m[a]   <= r_norm_n[a];
                r_mag_m[a]    <= n_mag[a];
                r_rev_m[a]    <= n_rev[a];
                r_out_norm[a] <= r_norm_m[a];
                r_out_spd[a]  <= n_spd[a];
                r_out_rev[a]  <= r_rev_m[a];
            end
        end
    end

    assign o_out_valid      = r_vld[LAST];
    assign o_norm_x         = r_out_norm[0];
    assign o_norm_y         = r_out_norm[1];
    assign o_left_speed     = r_out_spd[0];
    assign o_left_reverse   = r_out_rev[0];
    assign o_right_speed    = r_out_spd[1];
    assign o_right_reverse  = r_out_rev[1];
    assign o_not_calibrated = r_out_unc;

endmodule

`default_nettype wire

// ===== rtl/joystick_normalize_diff_drive_mix_top.sv =====
// Top level: joystick normalization and differential drive mixing.
//
//  port group    dir  handshake                    payload
//  cfg           in   i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//  sample in     in   i_in_valid  / o_in_ready     i_raw_x, i_raw_y
//  result out    out  o_out_valid / i_out_ready    o_norm_x/y, speeds, reverse, flag
//
// One sample pair per cycle sustained while results are taken. From input transaction
// to result valid a pair passes the queue, divider, normalize, mix and output registers; one quotient bit per stage.
// Reset (i_rst_n low, synchronous) clears calibration registers, queue and pipeline valids.
// An output stall freezes the pipeline; the front keeps taking samples until the
// 4-entry queue fills. Config writes are always taken.
`default_nettype none

module joystick_normalize_diff_drive_mix_top #(
    parameter int SAMPLE_BITS   = jndm_pkg::DEF_SAMPLE_BITS,
    parameter int FRACTION_BITS = jndm_pkg::DEF_FRACTION_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [jndm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [SAMPLE_BITS-1:0]            i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [SAMPLE_BITS-1:0]            i_raw_x,
    input  logic [SAMPLE_BITS-1:0]            i_raw_y,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [FRACTION_BITS+1:0]   o_norm_x,
    output logic signed [FRACTION_BITS+1:0]   o_norm_y,
    output logic [7:0]                        o_left_speed,
    output logic                              o_left_reverse,
    output logic [7:0]                        o_right_speed,
    output logic                              o_right_reverse,
    output logic                              o_not_calibrated
);
    import jndm_pkg::*;

    localparam int S  = SAMPLE_BITS;
    localparam int QW = $bits(t_item_cls) + 4 * S;

    logic         w_push, w_q_ready, w_q_valid, w_pop;
    t_item_cls    w_cls_in, w_cls_out;
    logic [S-1:0] w_diff_x_in, w_span_x_in, w_diff_y_in, w_span_y_in;
    logic [S-1:0] w_diff_x_out, w_span_x_out, w_diff_y_out, w_span_y_out;
    logic [QW-1:0] w_q_din, w_q_dout;

    jndm_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_raw_x     (i_raw_x),
        .i_raw_y     (i_raw_y),
        .i_q_ready   (w_q_ready),
        .o_push      (w_push),
        .o_cls       (w_cls_in),
        .o_diff_x    (w_diff_x_in),
        .o_span_x    (w_span_x_in),
        .o_diff_y    (w_diff_y_in),
        .o_span_y    (w_span_y_in)
    );

    assign w_q_din = {w_cls_in, w_diff_x_in, w_span_x_in, w_diff_y_in, w_span_y_in};

    jndm_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_q_din),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_dout)
    );

    assign {w_cls_out, w_diff_x_out, w_span_x_out, w_diff_y_out, w_span_y_out} = w_q_dout;

    jndm_back #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (w_q_valid),
        .o_pop            (w_pop),
        .i_cls            (w_cls_out),
        .i_diff_x         (w_diff_x_out),
        .i_span_x         (w_span_x_out),
        .i_diff_y         (w_diff_y_out),
        .i_span_y         (w_span_y_out),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_norm_x         (o_norm_x),
        .o_norm_y         (o_norm_y),
        .o_left_speed     (o_left_speed),
        .o_left_reverse   (o_left_reverse),
        .o_right_speed    (o_right_speed),
        .o_right_reverse  (o_right_reverse),
        .o_not_calibrated (o_not_calibrated)
    );

endmodule

`default_nettype wire

// ===== rtl/jndm_checker.sv =====
// Port-level assertions for the joystick mix top level, with its bind.
`default_nettype none

module jndm_checker #(
    parameter int FRACTION_BITS = 15
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input logic signed [FRACTION_BITS+1:0] o_norm_x,
    input logic signed [FRACTION_BITS+1:0] o_norm_y,
    input logic [7:0]                      o_left_speed,
    input logic                            o_left_reverse,
    input logic [7:0]                      o_right_speed,
    input logic                            o_right_reverse,
    input logic                            o_not_calibrated
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result transaction dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_norm_x) && $stable(o_norm_y)
            && $stable(o_left_speed) && $stable(o_right_speed))
        else $error("result payload changed while stalled");

    // uncalibrated result must be all zero with the flag set
    a_uncal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_not_calibrated |-> o_norm_x == '0 && o_norm_y == '0
            && o_left_speed == 8'h00 && o_right_speed == 8'h00
            && !o_left_reverse && !o_right_reverse)
        else $error("uncalibrated result not zeroed");

    // both axes at rest means no drive
    a_rest_no_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_norm_x == '0 && o_norm_y == '0 |->
            o_left_speed == 8'h00 && o_right_speed == 8'h00
            && !o_left_reverse && !o_right_reverse)
        else $error("drive output with both axes at rest");

endmodule

bind joystick_normalize_diff_drive_mix_top jndm_checker #(
    .FRACTION_BITS (FRACTION_BITS)
) u_jndm_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_norm_x         (o_norm_x),
    .o_norm_y         (o_norm_y),
    .o_left_speed     (o_left_speed),
    .o_left_reverse   (o_left_reverse),
    .o_right_speed    (o_right_speed),
    .o_right_reverse  (o_right_reverse),
    .o_not_calibrated (o_not_calibrated)
);

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the joystick normalize / differential drive mix block.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jndm_pkg::*;

    localparam int SB        = DEF_SAMPLE_BITS;
    localparam int FB        = DEF_FRACTION_BITS;
    localparam int FULL      = 1 << FB;
    localparam int SMAX      = (1 << SB) - 1;
    localparam int LATENCY   = FB + 4;
    localparam int IDLE_PCT  = 19;
    localparam int HOLD_CYC  = 400;
    localparam int PHASES    = 9;
    localparam int PER_PHASE = 195;
    localparam int SYNC_AT   = 97;
    localparam longint LIMIT_NS = 5_000_000;

    // indexes past the last register: writes must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LAST  = 3'd7;

    typedef struct {
        logic [SB-1:0] x;
        logic [SB-1:0] y;
        bit            sync;  // hold off until every pending result is back
    } stick_item_t;

    typedef struct packed {
        logic signed [FB+1:0] norm_x;
        logic signed [FB+1:0] norm_y;
        logic [7:0]           l_spd;
        logic                 l_rev;
        logic [7:0]           r_spd;
        logic                 r_rev;
        logic                 uncal;
    } mix_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SB-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic [SB-1:0] raw_x = '0;
    logic [SB-1:0] raw_y = '0;
    logic out_ready = 1'b0;

    logic o_cfg_ready, o_in_ready, o_out_valid;
    logic signed [FB+1:0] o_norm_x, o_norm_y;
    logic [7:0] o_left_speed, o_right_speed;
    logic o_left_reverse, o_right_reverse, o_not_calibrated;

    joystick_normalize_diff_drive_mix_top u_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_ready       (o_in_ready),
        .i_raw_x          (raw_x),
        .i_raw_y          (raw_y),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (out_ready),
        .o_norm_x         (o_norm_x),
        .o_norm_y         (o_norm_y),
        .o_left_speed     (o_left_speed),
        .o_left_reverse   (o_left_reverse),
        .o_right_speed    (o_right_speed),
        .o_right_reverse  (o_right_reverse),
        .o_not_calibrated (o_not_calibrated)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // calibration copy, indexed by register
    logic [SB-1:0] cal_reg [0:5] = '{default: '0};

    stick_item_t stick_q [$];
    mix_result_t drive_q [$];

    logic pair_taken = 1'b0;
    bit tx_steady = 0;
    bit rx_steady = 0;
    bit hold_req = 0;
    bit hold_done = 0;
    int hold_cnt = 0;
    int n_pairs = 0, n_results = 0, n_uncal = 0, n_reverse = 0;
    int n_cal_sets = 0, n_errors = 0;

    // signed Q15 deflection of one axis
    function automatic int axis_q15(int raw, int ctr, int lo, int hi);
        int diff, span, mag;
        bit neg;
        diff = 0;
        span = 0;
        mag = 0;
        neg = 0;
        if (raw < ctr) begin
            diff = ctr - raw;
            span = (ctr >= lo) ? ctr - lo : lo - ctr;
            neg = 1;
        end else if (raw > ctr) begin
            diff = raw - ctr;
            span = (hi >= ctr) ? hi - ctr : ctr - hi;
        end
        if (span != 0 && diff != 0) begin
            mag = (diff << FB) / span;
            if (mag > FULL) mag = FULL;
        end
        if (mag * 20 < FULL) mag = 0;  // 5% deadband
        return neg ? -mag : mag;
    endfunction

    // {reverse, speed} for one wheel
    function automatic logic [8:0] wheel_cmd(int v);
        int m;
        logic [7:0] spd;
        if (v > FULL) v = FULL;
        if (v < -FULL) v = -FULL;
        m = (v < 0) ? -v : v;
        spd = 8'((m * 255) >> FB);
        return {v < 0, spd};
    endfunction

    function automatic mix_result_t mix_predict(logic [SB-1:0] rx, logic [SB-1:0] ry);
        mix_result_t r;
        int nx, ny;
        r = '0;
        if (cal_reg[CFG_MIN_X] == cal_reg[CFG_MAX_X] ||
            cal_reg[CFG_MIN_Y] == cal_reg[CFG_MAX_Y]) begin
            r.uncal = 1'b1;
            return r;
        end
        nx = axis_q15(rx, cal_reg[CFG_CENTER_X], cal_reg[CFG_MIN_X], cal_reg[CFG_MAX_X]);
        ny = axis_q15(ry, cal_reg[CFG_CENTER_Y], cal_reg[CFG_MIN_Y], cal_reg[CFG_MAX_Y]);
        r.norm_x = (FB+2)'(nx);
        r.norm_y = (FB+2)'(ny);
        {r.l_rev, r.l_spd} = wheel_cmd(ny + nx);
        {r.r_rev, r.r_spd} = wheel_cmd(ny - nx);
        return r;
    endfunction

    function automatic void check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            n_errors++;
        end
    endfunction

    // sample driver: new pair offered at the falling edge
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || pair_taken) begin
            if (stick_q.size() == 0 || (!tx_steady && $urandom_range(99) < IDLE_PCT) ||
                (stick_q[0].sync && drive_q.size() != 0)) begin
                in_valid <= 1'b0;
            end else begin
                in_valid <= 1'b1;
                raw_x <= stick_q[0].x;
                raw_y <= stick_q[0].y;
                void'(stick_q.pop_front());
            end
        end
    end

    // result sink with random back-pressure and one long hold-off
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            out_ready <= 1'b0;
            hold_cnt++;
            if (hold_cnt >= HOLD_CYC) hold_done = 1;
        end else begin
            out_ready <= rx_steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // monitor: predict on input transaction, compare on output transaction
    always @(posedge clk) begin
        mix_result_t e;
        if (!rst_n) begin
            pair_taken <= 1'b0;
        end else begin
            pair_taken <= in_valid && o_in_ready;
            if (in_valid && o_in_ready) begin
                drive_q.push_back(mix_predict(raw_x, raw_y));
                n_pairs++;
            end
            if (o_out_valid && out_ready) begin
                n_results++;
                if (drive_q.size() == 0) begin
                    $error("result transaction with no pending sample pair");
                    n_errors++;
                end else begin
                    e = drive_q.pop_front();
                    check_field("norm_x", $signed(e.norm_x), $signed(o_norm_x));
                    check_field("norm_y", $signed(e.norm_y), $signed(o_norm_y));
                    check_field("left_speed", e.l_spd, o_left_speed);
                    check_field("left_reverse", e.l_rev, o_left_reverse);
                    check_field("right_speed", e.r_spd, o_right_speed);
                    check_field("right_reverse", e.r_rev, o_right_reverse);
                    check_field("not_calibrated", e.uncal, o_not_calibrated);
                    if (e.uncal) n_uncal++;
                    if (e.l_rev || e.r_rev) n_reverse++;
                end
            end
        end
    end

    task automatic add_item(int x, int y, bit sync = 0);
        stick_item_t it;
        it.x = SB'(x);
        it.y = SB'(y);
        it.sync = sync;
        stick_q.push_back(it);
    endtask

    // wait for the pipe to empty, then let the divider run out;
    // checked at the rising edge so the driver's falling-edge update is visible
    task automatic settle();
        while (stick_q.size() != 0 || in_valid || drive_q.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [SB-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!o_cfg_ready);
        if (idx <= CFG_MAX_Y) cal_reg[idx] = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_cal(int cx, int cy, int lx, int hx, int ly, int hy);
        cfg_write(CFG_CENTER_X, SB'(cx));
        cfg_write(CFG_CENTER_Y, SB'(cy));
        cfg_write(CFG_MIN_X, SB'(lx));
        cfg_write(CFG_MAX_X, SB'(hx));
        cfg_write(CFG_MIN_Y, SB'(ly));
        cfg_write(CFG_MAX_Y, SB'(hy));
        n_cal_sets++;
    endtask

    task automatic rand_axis(output int ctr, output int lo, output int hi);
        int mode;
        mode = $urandom_range(9);
        ctr = $urandom_range(SMAX);
        lo = $urandom_range(SMAX);
        hi = $urandom_range(SMAX);
        case (mode)
            0: hi = lo;                 // uncalibrated axis
            1: lo = ctr;                // no span below center
            2: hi = ctr;                // no span above center
            3: ;                        // anything goes, spans may point backwards
            4: begin
                ctr = $urandom_range(SMAX - 100, 100);
                lo = ctr - $urandom_range(40, 1);
                hi = ctr + $urandom_range(40, 1);
            end
            5: begin
                lo = 0;
                hi = SMAX;
            end
            default: begin
                ctr = $urandom_range(2600, 1500);
                lo = $urandom_range(300);
                hi = $urandom_range(SMAX, 3800);
            end
        endcase
    endtask

    function automatic int rand_pos(int ctr);
        int v, mode;
        mode = $urandom_range(19);
        if (mode < 12) return $urandom_range(SMAX);
        if (mode == 17) return ctr;
        if (mode == 18) return 0;
        if (mode == 19) return SMAX;
        // near center, around the deadband edge
        v = ctr + $urandom_range(400) - 200;
        if (v < 0) v = 0;
        if (v > SMAX) v = SMAX;
        return v;
    endfunction

    initial begin
        #(LIMIT_NS);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int cx, cy, lx, hx, ly, hy;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // registers come up zero, so the stick reads as uncalibrated
        add_item(0, SMAX);
        add_item(SMAX, 0);
        settle();

        load_cal(2048, 2048, 0, SMAX, 0, SMAX);
        cfg_write(CFG_IDX_SPARE, 12'h123);
        cfg_write(CFG_IDX_LAST, 12'hABC);
        add_item(0, 0);
        add_item(SMAX, SMAX);
        add_item(0, SMAX);
        add_item(SMAX, 0);
        add_item(2048, 2048);
        add_item(2150, 2048);   // just inside the deadband
        add_item(2151, 2048);   // just outside
        add_item(2048, 1946);
        add_item(2048, 1945);
        settle();

        // min at center on X, max at center on Y
        load_cal(1000, 3000, 1000, 3000, 100, 3000);
        add_item(500, 3500);
        add_item(2000, 2000);
        add_item(1000, 3000);
        settle();

        // min above center and max below it
        load_cal(2000, 2000, 3000, 1000, 3000, 1000);
        add_item(1500, 2500);
        add_item(2500, 1200);
        settle();

        // narrow span: most readings saturate
        load_cal(2048, 2048, 2000, 2100, 2000, 2100);
        add_item(SMAX, 0);
        add_item(2090, 2010);
        settle();

        // only Y uncalibrated
        load_cal(2048, 2048, 0, SMAX, 500, 500);
        add_item(SMAX, SMAX);
        add_item(2048, 2048);
        settle();

        load_cal(SMAX, 0, 0, SMAX, 0, SMAX);
        add_item(0, SMAX);
        add_item(SMAX, 0);
        add_item(1, 1);
        settle();

        for (int p = 0; p < PHASES; p++) begin
            tx_steady = (p == 2);
            rx_steady = (p == 2);
            rand_axis(cx, lx, hx);
            rand_axis(cy, ly, hy);
            load_cal(cx, cy, lx, hx, ly, hy);
            if (p == 4) hold_req = 1;
            for (int k = 0; k < PER_PHASE; k++)
                add_item(rand_pos(cx), rand_pos(cy), k == SYNC_AT);
            settle();
            hold_req = 0;
        end

        $display("Checked %0d results for %0d sample pairs across %0d calibrations.",
                 n_results, n_pairs, n_cal_sets);
        $display("%0d flagged uncalibrated, %0d with a wheel in reverse.", n_uncal, n_reverse);
        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
